@@ hdl/omni_pkg.sv @@
package omni_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN     = 24;
   localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam int ATAN_IDX_W   = $clog2(ATAN_LEN);

   localparam int K_LIN  = 23173;
   localparam int K_HEAD = 174993;
   localparam int K_GAIN = 39797;
   localparam int K_TIME = 1099512;

   localparam logic [1:0] REG_WHEEL_RADIUS   = 2'd0;
   localparam logic [1:0] REG_INV_CENTER_SUM = 2'd1;
   localparam logic [1:0] REG_MIN_STEP       = 2'd2;

   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
   localparam logic [OP_W-1:0] OP_SUM   = 4'd2;
   localparam logic [OP_W-1:0] OP_MUL1  = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL2  = 4'd4;
   localparam logic [OP_W-1:0] OP_TWIST = 4'd5;
   localparam logic [OP_W-1:0] OP_HMUL1 = 4'd6;
   localparam logic [OP_W-1:0] OP_HMUL2 = 4'd7;
   localparam logic [OP_W-1:0] OP_HEAD  = 4'd8;
   localparam logic [OP_W-1:0] OP_CINIT = 4'd9;
   localparam logic [OP_W-1:0] OP_CORD  = 4'd10;
   localparam logic [OP_W-1:0] OP_GAIN  = 4'd11;
   localparam logic [OP_W-1:0] OP_WRND  = 4'd12;
   localparam logic [OP_W-1:0] OP_WDT   = 4'd13;
   localparam logic [OP_W-1:0] OP_TMUL  = 4'd14;
   localparam logic [OP_W-1:0] OP_POS   = 4'd15;

   typedef struct packed {
      logic signed [15:0] front_left_speed;
      logic signed [15:0] rear_left_speed;
      logic signed [15:0] rear_right_speed;
      logic signed [15:0] front_right_speed;
      logic [15:0]        step_time;
   } req_payload_type;

   typedef struct packed {
      logic               accepted;
      logic signed [15:0] body_vx;
      logic signed [15:0] body_vy;
      logic signed [15:0] body_wz;
      logic signed [31:0] odom_x;
      logic signed [31:0] odom_y;
      logic [15:0]        odom_heading;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] wheel_radius;
      logic [15:0] inv_center_sum;
      logic [15:0] min_step;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ITER_W-1:0] iter;
      logic              do_tsum;
   } cmd_type;

   typedef struct packed {
      logic short_step;
   } status_type;

   function automatic logic signed [33:0] atan_val(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return $signed({2'b00, v});
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767)
         return 16'sh7FFF;
      else if (v < -64'sd32768)
         return 16'sh8000;
      else
         return v[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648)
         return 32'sh80000000;
      else
         return v[31:0];
   endfunction

endpackage

@@ hdl/omni_ctrl.sv @@
module omni_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  omni_pkg::status_type status,
   output omni_pkg::cmd_type    cmd
);
   import omni_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_MUL1  = 5'd2;
   localparam logic [4:0] S_MUL2  = 5'd3;
   localparam logic [4:0] S_TWIST = 5'd4;
   localparam logic [4:0] S_HMUL1 = 5'd5;
   localparam logic [4:0] S_HMUL2 = 5'd6;
   localparam logic [4:0] S_HEAD  = 5'd7;
   localparam logic [4:0] S_CINIT = 5'd8;
   localparam logic [4:0] S_CORD  = 5'd9;
   localparam logic [4:0] S_GAIN  = 5'd10;
   localparam logic [4:0] S_WRND  = 5'd11;
   localparam logic [4:0] S_WDT   = 5'd12;
   localparam logic [4:0] S_TMUL  = 5'd13;
   localparam logic [4:0] S_TSUM  = 5'd14;
   localparam logic [4:0] S_POS   = 5'd15;
   localparam logic [4:0] S_OUT   = 5'd16;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

   logic [4:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   always_comb begin
      state_in    = state_ff;
      iter_in     = iter_ff;
      cmd.op      = OP_NONE;
      cmd.iter    = iter_ff;
      cmd.do_tsum = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.short_step) begin
               state_in = S_OUT;
            end else begin
               cmd.op   = OP_SUM;
               state_in = S_MUL1;
            end
         end
         S_MUL1:  begin cmd.op = OP_MUL1;  state_in = S_MUL2;  end
         S_MUL2:  begin cmd.op = OP_MUL2;  state_in = S_TWIST; end
         S_TWIST: begin cmd.op = OP_TWIST; state_in = S_HMUL1; end
         S_HMUL1: begin cmd.op = OP_HMUL1; state_in = S_HMUL2; end
         S_HMUL2: begin cmd.op = OP_HMUL2; state_in = S_HEAD;  end
         S_HEAD:  begin cmd.op = OP_HEAD;  state_in = S_CINIT; end
         S_CINIT: begin
            cmd.op   = OP_CINIT;
            iter_in  = '0;
            state_in = S_CORD;
         end
         S_CORD: begin
            cmd.op  = OP_CORD;
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_GAIN;
            end
         end
         S_GAIN:  begin cmd.op = OP_GAIN;  state_in = S_WRND;  end
         S_WRND:  begin cmd.op = OP_WRND;  state_in = S_WDT;   end
         S_WDT:   begin cmd.op = OP_WDT;   state_in = S_TMUL;  end
         S_TMUL:  begin cmd.op = OP_TMUL;  state_in = S_TSUM;  end
         S_TSUM: begin
            cmd.do_tsum = 1'b1;
            state_in    = S_POS;
         end
         S_POS:   begin cmd.op = OP_POS;   state_in = S_OUT;   end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_load_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_CHECK))
      else $error("accepted transfer did not start work");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_cord_only_after_init: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORD && $past(state_ff) != S_CORD) |-> (iter_ff == '0))
      else $error("rotation started with a stale count");

endmodule

@@ hdl/omni_dp.sv @@
module omni_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  omni_pkg::cmd_type        cmd,
   input  omni_pkg::cfg_type        cfg,
   input  omni_pkg::req_payload_type req_payload,
   output omni_pkg::status_type     status,
   output omni_pkg::rsp_payload_type rsp_payload
);
   import omni_pkg::*;

   logic signed [15:0] fl_ff, rl_ff, rr_ff, fr_ff;
   logic [15:0]        dt_ff;
   logic               short_ff, acc_ff;
   logic signed [17:0] sa_ff, sb_ff, sc_ff;
   logic signed [34:0] pa_ff, pb_ff, pc_ff;
   logic signed [51:0] qa_ff, qb_ff, qc_ff;
   logic signed [15:0] vx_ff, vy_ff, wz_ff;
   logic signed [32:0] hw_ff;
   logic signed [51:0] hp_ff;
   logic [31:0]        heading_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [50:0] gx_ff, gy_ff;
   logic signed [28:0] wx_ff, wy_ff;
   logic signed [45:0] px_ff, py_ff;
   logic signed [46:0] mhx_ff, mhy_ff;
   logic [41:0]        mlx_ff, mly_ff;
   logic signed [67:0] tx_ff, ty_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff;

   logic signed [16:0] dt_s;
   logic signed [17:0] fl_e, rl_e, rr_e, fr_e;
   logic signed [52:0] qc_neg;
   logic signed [33:0] z_init, x_init, y_init, dx, dy, atan_i;
   logic [ATAN_IDX_W-1:0] atan_idx;
   logic signed [67:0] tx_sum, ty_sum;
   logic signed [27:0] dx_pos, dy_pos;

   localparam logic signed [16:0] K_LIN_S  = 17'(K_LIN);
   localparam logic signed [18:0] K_HEAD_S = 19'(K_HEAD);
   localparam logic signed [16:0] K_GAIN_S = 17'(K_GAIN);
   localparam logic signed [21:0] K_TIME_S = 22'(K_TIME);
   localparam logic [20:0]        K_TIME_U = 21'(K_TIME);
   localparam logic signed [33:0] QUARTER  = 34'sd1073741824;
   localparam logic signed [33:0] HALF     = 34'sd2147483648;

   assign dt_s = $signed({1'b0, dt_ff});
   assign fl_e = 18'(fl_ff);
   assign rl_e = 18'(rl_ff);
   assign rr_e = 18'(rr_ff);
   assign fr_e = 18'(fr_ff);
   assign qc_neg = -53'(qc_ff);

   always_comb begin
      z_init = $signed({{2{heading_ff[31]}}, heading_ff});
      x_init = 34'(vx_ff) <<< 14;
      y_init = 34'(vy_ff) <<< 14;
      if (z_init > QUARTER) begin
         z_init = z_init - HALF;
         x_init = -x_init;
         y_init = -y_init;
      end else if (z_init < -QUARTER) begin
         z_init = z_init + HALF;
         x_init = -x_init;
         y_init = -y_init;
      end
   end

   assign atan_idx = ATAN_IDX_W'(cmd.iter);
   assign atan_i   = atan_val(atan_idx);
   assign dx       = cy_ff >>> cmd.iter;
   assign dy       = cx_ff >>> cmd.iter;

   assign tx_sum = (68'(mhx_ff) <<< 21) + $signed({26'd0, mlx_ff}) + (68'sd1 <<< 39);
   assign ty_sum = (68'(mhy_ff) <<< 21) + $signed({26'd0, mly_ff}) + (68'sd1 <<< 39);
   assign dx_pos = 28'(tx_ff >>> 40);
   assign dy_pos = 28'(ty_ff >>> 40);

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         fl_ff <= req_payload.front_left_speed;
         rl_ff <= req_payload.rear_left_speed;
         rr_ff <= req_payload.rear_right_speed;
         fr_ff <= req_payload.front_right_speed;
         dt_ff <= req_payload.step_time;
      end
      if (cmd.op == OP_SUM) begin
         sa_ff <= fl_e + rl_e - rr_e - fr_e;
         sb_ff <= rl_e - fl_e + rr_e - fr_e;
         sc_ff <= fl_e + rl_e + rr_e + fr_e;
      end
      if (cmd.op == OP_MUL1) begin
         pa_ff <= sa_ff * $signed({1'b0, cfg.wheel_radius});
         pb_ff <= sb_ff * $signed({1'b0, cfg.wheel_radius});
         pc_ff <= sc_ff * $signed({1'b0, cfg.wheel_radius});
      end
      if (cmd.op == OP_MUL2) begin
         qa_ff <= pa_ff * K_LIN_S;
         qb_ff <= pb_ff * K_LIN_S;
         qc_ff <= pc_ff * $signed({1'b0, cfg.inv_center_sum});
      end
      if (cmd.op == OP_HMUL1) begin
         hw_ff <= wz_ff * dt_s;
      end
      if (cmd.op == OP_HMUL2) begin
         hp_ff <= hw_ff * K_HEAD_S;
      end
      if (cmd.op == OP_CINIT) begin
         cx_ff <= x_init;
         cy_ff <= y_init;
         cz_ff <= z_init;
      end
      if (cmd.op == OP_CORD) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - dx;
            cy_ff <= cy_ff + dy;
            cz_ff <= cz_ff - atan_i;
         end else begin
            cx_ff <= cx_ff + dx;
            cy_ff <= cy_ff - dy;
            cz_ff <= cz_ff + atan_i;
         end
      end
      if (cmd.op == OP_GAIN) begin
         gx_ff <= cx_ff * K_GAIN_S;
         gy_ff <= cy_ff * K_GAIN_S;
      end
      if (cmd.op == OP_WRND) begin
         wx_ff <= 29'((gx_ff + (51'sd1 <<< 21)) >>> 22);
         wy_ff <= 29'((gy_ff + (51'sd1 <<< 21)) >>> 22);
      end
      if (cmd.op == OP_WDT) begin
         px_ff <= wx_ff * dt_s;
         py_ff <= wy_ff * dt_s;
      end
      if (cmd.op == OP_TMUL) begin
         mhx_ff <= $signed(px_ff[45:21]) * K_TIME_S;
         mhy_ff <= $signed(py_ff[45:21]) * K_TIME_S;
         mlx_ff <= px_ff[20:0] * K_TIME_U;
         mly_ff <= py_ff[20:0] * K_TIME_U;
      end
      if (cmd.do_tsum) begin
         tx_ff <= tx_sum;
         ty_ff <= ty_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= 1'b0;
         acc_ff     <= 1'b0;
         vx_ff      <= '0;
         vy_ff      <= '0;
         wz_ff      <= '0;
         heading_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         if (cmd.op == OP_LOAD) begin
            short_ff <= (req_payload.step_time < cfg.min_step);
            acc_ff   <= (req_payload.step_time >= cfg.min_step);
         end
         if (cmd.op == OP_TWIST) begin
            vx_ff <= sat16(64'((qa_ff + (52'sd1 <<< 31)) >>> 32));
            vy_ff <= sat16(64'((qb_ff + (52'sd1 <<< 31)) >>> 32));
            wz_ff <= sat16(64'((qc_neg + (53'sd1 <<< 25)) >>> 26));
         end
         if (cmd.op == OP_HEAD) begin
            heading_ff <= heading_ff + 32'((hp_ff + (52'sd1 <<< 15)) >>> 16);
         end
         if (cmd.op == OP_POS) begin
            pos_x_ff <= sat32(64'(pos_x_ff) + 64'(dx_pos));
            pos_y_ff <= sat32(64'(pos_y_ff) + 64'(dy_pos));
         end
      end
   end

   assign status.short_step = short_ff;

   assign rsp_payload.accepted     = acc_ff;
   assign rsp_payload.body_vx      = vx_ff;
   assign rsp_payload.body_vy      = vy_ff;
   assign rsp_payload.body_wz      = wz_ff;
   assign rsp_payload.odom_x       = pos_x_ff;
   assign rsp_payload.odom_y       = pos_y_ff;
   assign rsp_payload.odom_heading = heading_ff[31:16];

endmodule

@@ hdl/omniwheel_odometry_integrator.sv @@
// Dead-reckoning odometry for a four-wheel 45-degree omni drive. Each transfer on
// req_ carries four wheel speeds and a step time and yields exactly one transfer on
// rsp_ with the twist, the position and the heading. One item at a time: an item
// that is integrated runs the iterative CORDIC rotation through the new heading
// before rsp_valid; a step shorter than min_step is answered from the check state
// with accepted low and nothing changed. Registers at paddr 0, 4 and 8:
// wheel_radius, inv_center_sum, min_step; write them only while no item is in
// flight.
module omniwheel_odometry_integrator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  omni_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output omni_pkg::rsp_payload_type  rsp_payload,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import omni_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_radius   <= 16'd0;
         cfg_ff.inv_center_sum <= 16'd256;
         cfg_ff.min_step       <= 16'd100;
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_WHEEL_RADIUS:   cfg_ff.wheel_radius   <= pwdata[15:0];
            REG_INV_CENTER_SUM: cfg_ff.inv_center_sum <= pwdata[15:0];
            REG_MIN_STEP:       cfg_ff.min_step       <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_WHEEL_RADIUS:   prdata = {16'd0, cfg_ff.wheel_radius};
         REG_INV_CENTER_SUM: prdata = {16'd0, cfg_ff.inv_center_sum};
         REG_MIN_STEP:       prdata = {16'd0, cfg_ff.min_step};
         default:            prdata = 32'd0;
      endcase
   end

   omni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   omni_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/tb_omniwheel_odometry_integrator.sv @@
`timescale 1ns / 1ps

module tb_omniwheel_odometry_integrator;
   import omni_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_payload_type req_payload;
   logic rsp_valid;
   logic rsp_stall;
   rsp_payload_type rsp_payload;
   logic psel;
   logic penable;
   logic pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   omniwheel_odometry_integrator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   req_payload_type pending_steps[$];
   rsp_payload_type expected_odom[$];
   int error_count;
   int cycle_count;
   int burst_left;
   int gap_left;
   bit hold_off;

   logic [15:0] m_radius, m_inv, m_min_step;
   logic signed [31:0] m_pos_x, m_pos_y;
   logic [31:0] m_heading;
   logic signed [15:0] m_vx, m_vy, m_wz;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint arctan_entry(input int i);
      logic [31:0] t[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
         32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
         32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
         32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
         32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return longint'(t[i]);
   endfunction

   task automatic integrate_step(input req_payload_type s);
      longint fl, rl, rr, fr, dt, r, x, y, z, wx, wy, dx, dy;
      rsp_payload_type e;
      fl = longint'(s.front_left_speed);
      rl = longint'(s.rear_left_speed);
      rr = longint'(s.rear_right_speed);
      fr = longint'(s.front_right_speed);
      dt = longint'(s.step_time);
      r = longint'(m_radius);
      e.accepted = 1'b0;
      if (s.step_time >= m_min_step) begin
         e.accepted = 1'b1;
         m_vx = 16'(clamp(round_shift((fl + rl - rr - fr) * r * K_LIN, 32), -32768, 32767));
         m_vy = 16'(clamp(round_shift((rl - fl + rr - fr) * r * K_LIN, 32), -32768, 32767));
         m_wz = 16'(clamp(round_shift(-((fl + rl + rr + fr) * r * longint'(m_inv)), 26),
                          -32768, 32767));
         m_heading = m_heading + 32'(round_shift(longint'(m_wz) * dt * K_HEAD, 16));
         z = longint'($signed(m_heading));
         x = longint'(m_vx) * 16384;
         y = longint'(m_vy) * 16384;
         if (z > (64'sd1 <<< 30)) begin
            z -= 64'sd1 <<< 31; x = -x; y = -y;
         end else if (z < -(64'sd1 <<< 30)) begin
            z += 64'sd1 <<< 31; x = -x; y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan_entry(i);
            end else begin
               x += dx; y -= dy; z += arctan_entry(i);
            end
         end
         wx = round_shift(x * K_GAIN, 22);
         wy = round_shift(y * K_GAIN, 22);
         m_pos_x = 32'(clamp(longint'(m_pos_x) + round_shift(wx * dt * K_TIME, 40),
                             -64'sd2147483648, 64'sd2147483647));
         m_pos_y = 32'(clamp(longint'(m_pos_y) + round_shift(wy * dt * K_TIME, 40),
                             -64'sd2147483648, 64'sd2147483647));
      end
      e.body_vx = m_vx;
      e.body_vy = m_vy;
      e.body_wz = m_wz;
      e.odom_x = m_pos_x;
      e.odom_y = m_pos_y;
      e.odom_heading = m_heading[31:16];
      expected_odom.push_back(e);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= {16'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_WHEEL_RADIUS:   m_radius = value;
         REG_INV_CENTER_SUM: m_inv = value;
         REG_MIN_STEP:       m_min_step = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      wait (pending_steps.size() == 0 && expected_odom.size() == 0 && !req_valid);
      repeat (CORDIC_STEPS + 24) @(posedge clock);
   endtask

   function automatic logic [15:0] edge_speed();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int n, input logic [15:0] min_dt);
      req_payload_type s;
      repeat (n) begin
         s.front_left_speed = ($urandom_range(0, 9) == 0) ? edge_speed() : 16'($urandom);
         s.rear_left_speed = ($urandom_range(0, 9) == 0) ? edge_speed() : 16'($urandom);
         s.rear_right_speed = ($urandom_range(0, 9) == 0) ? edge_speed() : 16'($urandom);
         s.front_right_speed = ($urandom_range(0, 9) == 0) ? edge_speed() : 16'($urandom);
         if ($urandom_range(0, 9) == 0)
            s.step_time = 16'($urandom_range(0, int'(min_dt)));
         else if ($urandom_range(0, 19) == 0)
            s.step_time = 16'hFFFF;
         else
            s.step_time = 16'($urandom);
         pending_steps.push_back(s);
      end
   endtask

   task automatic queue_step(input logic [15:0] a, b, c, d, dt);
      req_payload_type s;
      s = '{a, b, c, d, dt};
      pending_steps.push_back(s);
   endtask

   initial begin
      logic [15:0] radii[4] = '{16'h0000, 16'hFFFF, 16'h1000, 16'h0800};
      logic [15:0] invs[4] = '{16'h0000, 16'hFFFF, 16'h0100, 16'h0180};
      logic [15:0] mins[4] = '{16'h0000, 16'hFFFF, 16'd100, 16'd1000};
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      error_count = 0; cycle_count = 0; burst_left = 0; gap_left = 0; hold_off = 1'b0;
      m_radius = 16'd0; m_inv = 16'd256; m_min_step = 16'd100;
      m_pos_x = 0; m_pos_y = 0; m_heading = 0; m_vx = 0; m_vy = 0; m_wz = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      queue_step(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd1000);
      drain();
      write_reg(REG_WHEEL_RADIUS, 16'hFFFF);
      write_reg(REG_INV_CENTER_SUM, 16'hFFFF);
      write_reg(REG_MIN_STEP, 16'd100);
      queue_step(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
      queue_step(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      queue_step(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      queue_step(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'd100);
      queue_step(16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0, 16'd99);
      queue_step(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0);
      repeat (6) queue_step(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF);
      repeat (6) queue_step(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF);
      queue_step(16'h0400, 16'h0000, 16'hFC00, 16'h0000, 16'd5000);
      drain();
      write_reg(REG_INV_CENTER_SUM, 16'h0000);
      write_reg(REG_MIN_STEP, 16'hFFFF);
      queue_step(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'hFFFE);
      queue_step(16'h0100, 16'h0200, 16'h0300, 16'h0400, 16'hFFFF);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         write_reg(REG_WHEEL_RADIUS, (phase % 3 == 0) ? radii[$urandom_range(0, 3)]
                                                      : 16'($urandom));
         write_reg(REG_INV_CENTER_SUM, (phase % 3 == 1) ? invs[$urandom_range(0, 3)]
                                                        : 16'($urandom));
         write_reg(REG_MIN_STEP, (phase % 4 == 3) ? mins[$urandom_range(0, 3)]
                                                  : 16'($urandom_range(0, 2000)));
         queue_random(125, m_min_step);
         if (phase == 5) begin
            wait (pending_steps.size() == 60);
            hold_off = 1'b1;
            wait (expected_odom.size() == 0 && !req_valid);
            hold_off = 1'b0;
         end
         drain();
      end

      drain();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            integrate_step(req_payload);
         end
         if (req_valid && req_stall) begin
         end else if (hold_off || pending_steps.size() == 0) begin
            req_valid <= 1'b0;
         end else if (burst_left > 0) begin
            req_payload <= pending_steps.pop_front();
            req_valid <= 1'b1;
            burst_left <= burst_left - 1;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else begin
            req_valid <= 1'b0;
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_odom.size() == 0) begin
               $display("%0t unexpected transfer: expected none, actual %h", $time, rsp_payload);
               error_count <= error_count + 1;
            end else begin
               e = expected_odom.pop_front();
               if (rsp_payload !== e) begin
                  $display("%0t mismatch: expected %h, actual %h", $time, e, rsp_payload);
                  error_count <= error_count + 1;
               end
            end
         end
         case ((cycle_count / 500) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= ((cycle_count % 37) < 20);
         endcase
      end
   end

endmodule

@@ files.f @@
hdl/omni_pkg.sv
hdl/omni_ctrl.sv
hdl/omni_dp.sv
hdl/omniwheel_odometry_integrator.sv
tb/tb_omniwheel_odometry_integrator.sv
